[hdl/ptt_pkg.sv]
package ptt_pkg;

   localparam int LINE_BITS = 16;
   localparam int FIFO_DEPTH = 4;
   localparam int MAX_RESULTS = 3;

   localparam logic [20:0] CH_TAB = 21'h09;
   localparam logic [20:0] CH_LF = 21'h0A;
   localparam logic [20:0] CH_CR = 21'h0D;
   localparam logic [20:0] CH_SPACE = 21'h20;
   localparam logic [20:0] CH_HASH = 21'h23;
   localparam logic [20:0] CH_BANG = 21'h21;
   localparam logic [20:0] CH_EQUALS = 21'h3D;
   localparam logic [20:0] CH_DOT = 21'h2E;
   localparam logic [20:0] CH_BACKSLASH = 21'h5C;
   localparam logic [20:0] CH_LOWER_N = 21'h6E;
   localparam logic [20:0] CH_LOWER_R = 21'h72;
   localparam logic [20:0] CH_LOWER_T = 21'h74;
   localparam logic [20:0] CH_LOWER_U = 21'h75;
   localparam logic [3:0] HEX_DIGITS = 4'd8;

   typedef enum logic [2:0] {
      KIND_KEY_CHAR = 3'd0,
      KIND_KEY_PART_END = 3'd1,
      KIND_KEY_END = 3'd2,
      KIND_VALUE_CHAR = 3'd3,
      KIND_VALUE_END = 3'd4,
      KIND_ERROR = 3'd5
   } kind_type;

   typedef enum logic [9:0] {
      ST_IDLE = 10'b0000000001,
      ST_COMMENT = 10'b0000000010,
      ST_KEY = 10'b0000000100,
      ST_KEY_ESC = 10'b0000001000,
      ST_KEY_HEX = 10'b0000010000,
      ST_KEY_BLANK = 10'b0000100000,
      ST_VALUE = 10'b0001000000,
      ST_VALUE_ESC = 10'b0010000000,
      ST_VALUE_HEX = 10'b0100000000,
      ST_ERROR = 10'b1000000000
   } state_type;

   typedef struct packed {
      kind_type kind;
      logic [31:0] char_out;
      logic [15:0] line_number;
      logic last;
   } rsp_entry_type;

endpackage

[hdl/properties_text_tokenizer_top.sv]
// Results are registered into the result queue when their request is accepted.
// Throughput: one request per cycle while each yields at most one result and rsp
// is taken every cycle; rsp delivers one result per cycle while rsp_tready is high.
// A request gives k results (0..3), buffered in a four-entry result queue.
// Reset (synchronous, active high): idle state, empty queue, line count one.
module properties_text_tokenizer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [20:0] char_code, [23:21] zero
   input  logic [0:0]  req_tuser,   // [0] end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [31:0] char_out, [47:32] line_number
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast
);

   localparam int PTR_BITS = $clog2(ptt_pkg::FIFO_DEPTH);

   ptt_pkg::state_type state_ff, state_in;
   logic value_started_ff, value_started_in;
   logic [31:0] code_accum_ff, code_accum_in;
   logic [3:0] digit_count_ff, digit_count_in;
   logic [ptt_pkg::LINE_BITS-1:0] line_count_ff, line_count_in;

   ptt_pkg::rsp_entry_type queue_ff [ptt_pkg::FIFO_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0] count_ff, count_in;

   logic accept, pop;
   logic [20:0] c;
   logic eoi;
   logic is_blank, is_key_char, is_digit, is_alpha_hex, is_hex, reprocess;
   logic [3:0] hex_val;
   logic [31:0] line_wide;
   ptt_pkg::kind_type res_kind [ptt_pkg::MAX_RESULTS];
   logic [31:0] res_char [ptt_pkg::MAX_RESULTS];
   logic [1:0] res_n;

   function automatic logic [31:0] unescape(input logic [20:0] ch);
      logic [31:0] r;
      r = 32'(ch);
      if (ch == ptt_pkg::CH_LOWER_N) r = 32'(ptt_pkg::CH_LF);
      else if (ch == ptt_pkg::CH_LOWER_R) r = 32'(ptt_pkg::CH_CR);
      else if (ch == ptt_pkg::CH_LOWER_T) r = 32'(ptt_pkg::CH_TAB);
      return r;
   endfunction

   assign req_tready = (count_ff <= (PTR_BITS+1)'(ptt_pkg::FIFO_DEPTH - ptt_pkg::MAX_RESULTS));
   assign accept = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign pop = rsp_tvalid && rsp_tready;

   assign c = req_tdata[20:0];
   assign eoi = req_tuser[0];

   assign is_blank = (c == ptt_pkg::CH_SPACE) || (c >= ptt_pkg::CH_TAB && c <= ptt_pkg::CH_CR);
   assign is_digit = (c >= 21'h30 && c <= 21'h39);
   assign is_alpha_hex = (c >= 21'h61 && c <= 21'h66) || (c >= 21'h41 && c <= 21'h46);
   assign is_hex = is_digit || is_alpha_hex;
   assign hex_val = is_digit ? c[3:0] : c[3:0] + 4'd9;
   assign is_key_char = (c >= 21'h61 && c <= 21'h7A) || (c >= 21'h41 && c <= 21'h5A)
                        || is_digit || (c == 21'h5F);

   // line count moves before any result of this request is formed
   always_comb begin
      line_count_in = line_count_ff;
      if (accept && state_ff != ptt_pkg::ST_ERROR && !eoi && c == ptt_pkg::CH_LF
          && line_count_ff != '1) begin
         line_count_in = line_count_ff + 1'b1;
      end
   end

   assign line_wide = 32'(line_count_in);

   always_comb begin
      state_in = state_ff;
      value_started_in = value_started_ff;
      code_accum_in = code_accum_ff;
      digit_count_in = digit_count_ff;
      reprocess = 1'b0;
      res_n = 2'd0;
      for (int i = 0; i < ptt_pkg::MAX_RESULTS; i++) begin
         res_kind[i] = ptt_pkg::KIND_ERROR;
         res_char[i] = '0;
      end

      if (accept && state_ff != ptt_pkg::ST_ERROR) begin
         if (eoi) begin
            unique case (state_ff)
               ptt_pkg::ST_VALUE, ptt_pkg::ST_VALUE_ESC: begin
                  res_kind[res_n] = ptt_pkg::KIND_VALUE_END;
                  res_n = res_n + 2'd1;
                  state_in = ptt_pkg::ST_IDLE;
                  value_started_in = 1'b0;
               end
               ptt_pkg::ST_VALUE_HEX: begin
                  if (digit_count_ff == '0) begin
                     res_kind[res_n] = ptt_pkg::KIND_ERROR;
                     res_n = res_n + 2'd1;
                     state_in = ptt_pkg::ST_ERROR;
                  end else begin
                     res_kind[res_n] = ptt_pkg::KIND_VALUE_CHAR;
                     res_char[res_n] = code_accum_ff;
                     res_n = res_n + 2'd1;
                     res_kind[res_n] = ptt_pkg::KIND_VALUE_END;
                     res_n = res_n + 2'd1;
                     state_in = ptt_pkg::ST_IDLE;
                     value_started_in = 1'b0;
                  end
               end
               ptt_pkg::ST_IDLE, ptt_pkg::ST_COMMENT: begin
                  state_in = ptt_pkg::ST_IDLE;
                  value_started_in = 1'b0;
               end
               ptt_pkg::ST_KEY, ptt_pkg::ST_KEY_ESC, ptt_pkg::ST_KEY_HEX,
               ptt_pkg::ST_KEY_BLANK: begin
                  res_kind[res_n] = ptt_pkg::KIND_ERROR;
                  res_n = res_n + 2'd1;
                  state_in = ptt_pkg::ST_ERROR;
               end
               default: begin
               end
            endcase
         end else begin
            // hex escape first; a non-hex character that ends it after a digit is then parsed again
            if (state_ff == ptt_pkg::ST_KEY_HEX || state_ff == ptt_pkg::ST_VALUE_HEX) begin
               if (!is_hex) begin
                  if (digit_count_ff == '0) begin
                     res_kind[res_n] = ptt_pkg::KIND_ERROR;
                     res_n = res_n + 2'd1;
                     state_in = ptt_pkg::ST_ERROR;
                  end else begin
                     res_char[res_n] = code_accum_ff;
                     if (state_ff == ptt_pkg::ST_VALUE_HEX) begin
                        res_kind[res_n] = ptt_pkg::KIND_VALUE_CHAR;
                        value_started_in = 1'b1;
                        state_in = ptt_pkg::ST_VALUE;
                     end else begin
                        res_kind[res_n] = ptt_pkg::KIND_KEY_CHAR;
                        state_in = ptt_pkg::ST_KEY;
                     end
                     res_n = res_n + 2'd1;
                     reprocess = 1'b1;
                  end
               end else begin
                  code_accum_in = {code_accum_ff[27:0], hex_val};
                  digit_count_in = digit_count_ff + 4'd1;
                  if (digit_count_in >= ptt_pkg::HEX_DIGITS) begin
                     res_char[res_n] = code_accum_in;
                     if (state_ff == ptt_pkg::ST_VALUE_HEX) begin
                        res_kind[res_n] = ptt_pkg::KIND_VALUE_CHAR;
                        value_started_in = 1'b1;
                        state_in = ptt_pkg::ST_VALUE;
                     end else begin
                        res_kind[res_n] = ptt_pkg::KIND_KEY_CHAR;
                        state_in = ptt_pkg::ST_KEY;
                     end
                     res_n = res_n + 2'd1;
                  end
               end
            end else begin
               reprocess = 1'b1;
            end

            if (reprocess) begin
               unique case (state_in)
                  ptt_pkg::ST_IDLE: begin
                     if (c == ptt_pkg::CH_HASH || c == ptt_pkg::CH_BANG) begin
                        state_in = ptt_pkg::ST_COMMENT;
                     end else if (is_key_char) begin
                        res_kind[res_n] = ptt_pkg::KIND_KEY_CHAR;
                        res_char[res_n] = 32'(c);
                        res_n = res_n + 2'd1;
                        state_in = ptt_pkg::ST_KEY;
                     end else if (c == ptt_pkg::CH_BACKSLASH) begin
                        state_in = ptt_pkg::ST_KEY_ESC;
                     end else if (!is_blank) begin
                        res_kind[res_n] = ptt_pkg::KIND_ERROR;
                        res_n = res_n + 2'd1;
                        state_in = ptt_pkg::ST_ERROR;
                     end
                  end
                  ptt_pkg::ST_COMMENT: begin
                     if (c == ptt_pkg::CH_LF) state_in = ptt_pkg::ST_IDLE;
                  end
                  ptt_pkg::ST_KEY: begin
                     if (c == ptt_pkg::CH_DOT) begin
                        res_kind[res_n] = ptt_pkg::KIND_KEY_PART_END;
                        res_n = res_n + 2'd1;
                     end else if (is_key_char) begin
                        res_kind[res_n] = ptt_pkg::KIND_KEY_CHAR;
                        res_char[res_n] = 32'(c);
                        res_n = res_n + 2'd1;
                     end else if (is_blank || c == ptt_pkg::CH_EQUALS) begin
                        res_kind[res_n] = ptt_pkg::KIND_KEY_PART_END;
                        res_n = res_n + 2'd1;
                        res_kind[res_n] = ptt_pkg::KIND_KEY_END;
                        res_n = res_n + 2'd1;
                        state_in = (c == ptt_pkg::CH_EQUALS) ? ptt_pkg::ST_VALUE
                                                             : ptt_pkg::ST_KEY_BLANK;
                     end else if (c == ptt_pkg::CH_BACKSLASH) begin
                        state_in = ptt_pkg::ST_KEY_ESC;
                     end else begin
                        res_kind[res_n] = ptt_pkg::KIND_ERROR;
                        res_n = res_n + 2'd1;
                        state_in = ptt_pkg::ST_ERROR;
                     end
                  end
                  ptt_pkg::ST_KEY_ESC: begin
                     if (c == ptt_pkg::CH_LOWER_U) begin
                        code_accum_in = '0;
                        digit_count_in = '0;
                        state_in = ptt_pkg::ST_KEY_HEX;
                     end else begin
                        res_kind[res_n] = ptt_pkg::KIND_KEY_CHAR;
                        res_char[res_n] = unescape(c);
                        res_n = res_n + 2'd1;
                        state_in = ptt_pkg::ST_KEY;
                     end
                  end
                  ptt_pkg::ST_KEY_BLANK: begin
                     if (c == ptt_pkg::CH_EQUALS) begin
                        state_in = ptt_pkg::ST_VALUE;
                     end else if (!is_blank) begin
                        res_kind[res_n] = ptt_pkg::KIND_ERROR;
                        res_n = res_n + 2'd1;
                        state_in = ptt_pkg::ST_ERROR;
                     end
                  end
                  ptt_pkg::ST_VALUE: begin
                     if (c == ptt_pkg::CH_LF) begin
                        res_kind[res_n] = ptt_pkg::KIND_VALUE_END;
                        res_n = res_n + 2'd1;
                        value_started_in = 1'b0;
                        state_in = ptt_pkg::ST_IDLE;
                     end else if (c == ptt_pkg::CH_BACKSLASH) begin
                        state_in = ptt_pkg::ST_VALUE_ESC;
                     end else if (value_started_in || !is_blank) begin
                        res_kind[res_n] = ptt_pkg::KIND_VALUE_CHAR;
                        res_char[res_n] = 32'(c);
                        res_n = res_n + 2'd1;
                        value_started_in = 1'b1;
                     end
                  end
                  ptt_pkg::ST_VALUE_ESC: begin
                     if (c == ptt_pkg::CH_LOWER_U) begin
                        code_accum_in = '0;
                        digit_count_in = '0;
                        state_in = ptt_pkg::ST_VALUE_HEX;
                     end else begin
                        res_kind[res_n] = ptt_pkg::KIND_VALUE_CHAR;
                        res_char[res_n] = unescape(c);
                        res_n = res_n + 2'd1;
                        value_started_in = 1'b1;
                        state_in = ptt_pkg::ST_VALUE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(res_n);
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + (PTR_BITS+1)'(res_n) - (PTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptt_pkg::ST_IDLE;
         value_started_ff <= 1'b0;
         code_accum_ff <= '0;
         digit_count_ff <= '0;
         line_count_ff <= ptt_pkg::LINE_BITS'(1);
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         value_started_ff <= value_started_in;
         code_accum_ff <= code_accum_in;
         digit_count_ff <= digit_count_in;
         line_count_ff <= line_count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ptt_pkg::MAX_RESULTS; i++) begin
         if (2'(i) < res_n) begin
            queue_ff[wr_ptr_ff + PTR_BITS'(i)] <= '{
               kind: res_kind[i],
               char_out: res_char[i],
               line_number: line_wide[15:0],
               last: (2'(i) == res_n - 2'd1)
            };
         end
      end
   end

   assign rsp_tuser = queue_ff[rd_ptr_ff].kind;
   assign rsp_tdata = {queue_ff[rd_ptr_ff].line_number, queue_ff[rd_ptr_ff].char_out};
   assign rsp_tlast = queue_ff[rd_ptr_ff].last;

endmodule
